// ----- sv/hse_pkg.sv -----
package hse_pkg;

   localparam int ELEM_W = 32;

   typedef enum logic [3:0] {
      CMD_NONE        = 4'd0,
      CMD_TAKE        = 4'd1,
      CMD_TAKE_LAST   = 4'd2,
      CMD_BUILD_FETCH = 4'd3,
      CMD_LATCH_ROOT  = 4'd4,
      CMD_SIFT_READ   = 4'd5,
      CMD_SIFT_STEP   = 4'd6,
      CMD_SORT_INIT   = 4'd7,
      CMD_SORT_FETCH  = 4'd8,
      CMD_SORT_SWAP   = 4'd9,
      CMD_OUT_INIT    = 4'd10,
      CMD_OUT_READ    = 4'd11,
      CMD_OUT_LOAD    = 4'd12,
      CMD_OUT_SEND    = 4'd13
   } dp_cmd_type;

   typedef struct packed {
      logic outer_zero;
      logic outer_le1;
      logic left_ok;
      logic moving;
      logic out_last;
   } dp_status_type;

endpackage

// ----- sv/hse_dp.sv -----
module hse_dp #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hse_pkg::dp_cmd_type           cmd,
   input  logic [hse_pkg::ELEM_W-1:0]    in_value,
   output hse_pkg::dp_status_type        status,
   output logic [hse_pkg::ELEM_W-1:0]    out_value,
   output logic                          out_end,
   output logic                          out_ovf
);
   import hse_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = IW + 2;

   logic signed [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [CW-1:0]                count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic [CW-1:0]                outer_ff, outer_in;
   logic [IW-1:0]                node_ff, node_in;
   logic [CW-1:0]                size_ff, size_in;
   logic signed [DATA_WIDTH-1:0] val_ff, val_in;
   logic signed [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [ELEM_W-1:0]            sorted_ff, sorted_in;
   logic                         end_ff, end_in;

   logic                         we;
   logic [IW-1:0]                wa, ra, rb;
   logic signed [DATA_WIDTH-1:0] wd;

   logic signed [DATA_WIDTH-1:0] in_conv;
   logic [ELEM_W-1:0]            out_conv;

   logic                         count_full;
   logic [CW-1:0]                count_nx, outer_dec;
   logic [XW-1:0]                left_x, right_x, size_x;
   logic                         left_ok, right_ok, left_big, right_big, moving, sift_done;
   logic signed [DATA_WIDTH-1:0] top_val, child_val;
   logic [IW-1:0]                child_idx;

   generate
      if (DATA_WIDTH <= ELEM_W) begin : g_in_narrow
         assign in_conv = in_value[DATA_WIDTH-1:0];
      end else begin : g_in_wide
         assign in_conv = {{(DATA_WIDTH-ELEM_W){in_value[ELEM_W-1]}}, in_value};
      end
      if (DATA_WIDTH >= ELEM_W) begin : g_out_wide
         assign out_conv = rd_a_ff[ELEM_W-1:0];
      end else begin : g_out_narrow
         assign out_conv = {{(ELEM_W-DATA_WIDTH){rd_a_ff[DATA_WIDTH-1]}}, rd_a_ff};
      end
   endgenerate

   assign count_full = (count_ff == CW'(CAPACITY));
   assign count_nx   = count_full ? count_ff : count_ff + CW'(1);
   assign outer_dec  = outer_ff - CW'(1);

   // children of node: 2n+1 and 2n+2
   assign left_x   = {1'b0, node_ff, 1'b1};
   assign right_x  = left_x + XW'(1);
   assign size_x   = XW'(size_ff);
   assign left_ok  = left_x < size_x;
   assign right_ok = right_x < size_x;

   assign left_big  = rd_a_ff > val_ff;
   assign top_val   = left_big ? rd_a_ff : val_ff;
   assign right_big = right_ok && (rd_b_ff > top_val);
   assign moving    = left_big || right_big;
   assign child_idx = right_big ? right_x[IW-1:0] : left_x[IW-1:0];
   assign child_val = right_big ? rd_b_ff : rd_a_ff;

   assign sift_done = ((cmd == CMD_SIFT_READ) && !left_ok) ||
                      ((cmd == CMD_SIFT_STEP) && !moving);

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      outer_in  = sift_done ? outer_dec : outer_ff;
      node_in   = node_ff;
      size_in   = size_ff;
      val_in    = val_ff;
      sorted_in = sorted_ff;
      end_in    = end_ff;
      we        = 1'b0;
      wa        = node_ff;
      wd        = val_ff;
      ra        = '0;
      rb        = '0;
      case (cmd)
         CMD_TAKE, CMD_TAKE_LAST: begin
            if (count_full) begin
               ovf_in = 1'b1;
            end else begin
               we       = 1'b1;
               wa       = count_ff[IW-1:0];
               wd       = in_conv;
               count_in = count_nx;
            end
            if (cmd == CMD_TAKE_LAST) begin
               outer_in = count_nx >> 1;
            end
         end
         CMD_BUILD_FETCH: begin
            ra      = outer_dec[IW-1:0];
            node_in = outer_dec[IW-1:0];
            size_in = count_ff;
         end
         CMD_LATCH_ROOT: begin
            val_in = rd_a_ff;
         end
         CMD_SIFT_READ: begin
            if (left_ok) begin
               ra = left_x[IW-1:0];
               rb = right_ok ? right_x[IW-1:0] : left_x[IW-1:0];
            end else begin
               we = 1'b1;
            end
         end
         CMD_SIFT_STEP: begin
            we = 1'b1;
            if (moving) begin
               wd      = child_val;
               node_in = child_idx;
            end
         end
         CMD_SORT_INIT: begin
            outer_in = count_ff;
         end
         CMD_SORT_FETCH: begin
            ra = '0;
            rb = outer_dec[IW-1:0];
         end
         CMD_SORT_SWAP: begin
            we      = 1'b1;
            wa      = outer_dec[IW-1:0];
            wd      = rd_a_ff;
            val_in  = rd_b_ff;
            node_in = '0;
            size_in = outer_dec;
         end
         CMD_OUT_INIT: begin
            outer_in = '0;
         end
         CMD_OUT_READ: begin
            ra = outer_ff[IW-1:0];
         end
         CMD_OUT_LOAD: begin
            sorted_in = out_conv;
            end_in    = (outer_ff + CW'(1)) == count_ff;
         end
         CMD_OUT_SEND: begin
            if (end_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               outer_in = outer_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_a_ff <= mem[ra];
      rd_b_ff <= mem[rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         outer_ff <= '0;
         end_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         outer_ff <= outer_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      size_ff   <= size_in;
      val_ff    <= val_in;
      sorted_ff <= sorted_in;
   end

   assign status.outer_zero = (outer_ff == '0);
   assign status.outer_le1  = (outer_ff <= CW'(1));
   assign status.left_ok    = left_ok;
   assign status.moving     = moving;
   assign status.out_last   = end_ff;

   assign out_value = sorted_ff;
   assign out_end   = end_ff;
   assign out_ovf   = ovf_ff;

endmodule

// ----- sv/hse_ctrl.sv -----
module hse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   input  logic                   rsp_tready,
   input  hse_pkg::dp_status_type status,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   output hse_pkg::dp_cmd_type    cmd
);
   import hse_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_BUILD_CHK = 10'b00_0000_0010,
      ST_BUILD_GET = 10'b00_0000_0100,
      ST_SIFT_RD   = 10'b00_0000_1000,
      ST_SIFT_CMP  = 10'b00_0001_0000,
      ST_SORT_CHK  = 10'b00_0010_0000,
      ST_SORT_SWAP = 10'b00_0100_0000,
      ST_OUT_READ  = 10'b00_1000_0000,
      ST_OUT_LOAD  = 10'b01_0000_0000,
      ST_OUT_WAIT  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;   // 1 while in the extraction phase
   state_type after_sift;

   assign after_sift = phase_ff ? ST_SORT_CHK : ST_BUILD_CHK;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT_WAIT);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tlast) begin
                  cmd      = CMD_TAKE_LAST;
                  phase_in = 1'b0;
                  state_in = ST_BUILD_CHK;
               end else begin
                  cmd = CMD_TAKE;
               end
            end
         end
         ST_BUILD_CHK: begin
            if (status.outer_zero) begin
               cmd      = CMD_SORT_INIT;
               phase_in = 1'b1;
               state_in = ST_SORT_CHK;
            end else begin
               cmd      = CMD_BUILD_FETCH;
               state_in = ST_BUILD_GET;
            end
         end
         ST_BUILD_GET: begin
            cmd      = CMD_LATCH_ROOT;
            state_in = ST_SIFT_RD;
         end
         ST_SIFT_RD: begin
            cmd      = CMD_SIFT_READ;
            state_in = status.left_ok ? ST_SIFT_CMP : after_sift;
         end
         ST_SIFT_CMP: begin
            cmd      = CMD_SIFT_STEP;
            state_in = status.moving ? ST_SIFT_RD : after_sift;
         end
         ST_SORT_CHK: begin
            if (status.outer_le1) begin
               cmd      = CMD_OUT_INIT;
               state_in = ST_OUT_READ;
            end else begin
               cmd      = CMD_SORT_FETCH;
               state_in = ST_SORT_SWAP;
            end
         end
         ST_SORT_SWAP: begin
            cmd      = CMD_SORT_SWAP;
            state_in = ST_SIFT_RD;
         end
         ST_OUT_READ: begin
            cmd      = CMD_OUT_READ;
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            cmd      = CMD_OUT_LOAD;
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               cmd      = CMD_OUT_SEND;
               state_in = status.out_last ? ST_IDLE : ST_OUT_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- sv/heap_sort_engine.sv -----
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: element_value; tlast: end_of_set
// rsp     | out | rsp_tvalid/rsp_tready | tdata: sorted_value; tlast: end_of_run;
//         |     |                       | tuser: overflowed
//
// Loading takes one word per cycle while idle. After the closing word the set is
// heapsorted in the element memory; each sift level is a child read followed by a
// compare and write. Each result is then read, loaded and shown until it is taken;
// the next one is not read before that. reset clears count, overflow flag and
// controller state; the memory is not cleared. While results stall, req_tready
// stays low.
module heap_sort_engine #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [hse_pkg::ELEM_W-1:0] req_tdata,   // [31:0] element_value
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [hse_pkg::ELEM_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic                       rsp_tlast,
   output logic                       rsp_tuser    // [0] overflowed
);
   import hse_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   hse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   hse_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_value  (req_tdata),
      .status    (status),
      .out_value (rsp_tdata),
      .out_end   (rsp_tlast),
      .out_ovf   (rsp_tuser)
   );

endmodule

// ----- sv/hse_checker.sv -----
module hse_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       req_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [hse_pkg::ELEM_W-1:0] rsp_tdata,
   input logic                       rsp_tlast,
   input logic                       rsp_tuser
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");

   a_closed_set: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after closing word");

   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not idle after last result");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import hse_pkg::*;

   localparam int CAP       = 64;
   localparam int HOLD_LEN  = 400;

   typedef struct {
      logic [ELEM_W-1:0] value;
      logic              last;
      bit                wait_drain;
   } element_word_type;

   typedef struct {
      logic [ELEM_W-1:0] value;
      logic              run_end;
      logic              dropped;
   } sorted_word_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ELEM_W-1:0] req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [ELEM_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;

   element_word_type  element_feed[$];
   element_word_type  next_word;
   sorted_word_type   sorted_expect[$];

   logic signed [ELEM_W-1:0] sort_buf [CAP];
   int                held = 0;
   bit                spilled = 0;

   int                words_queued = 0;
   int                words_taken = 0;
   int                errs = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                hold_asks = 0;
   int                hold_seen = 0;
   int                hold_left = 0;

   heap_sort_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   // max-heap sift over the first size entries
   function automatic void sift_element(int size, int node);
      int top;
      bit moving;
      logic signed [ELEM_W-1:0] t;
      moving = 1;
      while (moving) begin
         top = node;
         if (2 * node + 1 < size && sort_buf[2 * node + 1] > sort_buf[top])
            top = 2 * node + 1;
         if (2 * node + 2 < size && sort_buf[2 * node + 2] > sort_buf[top])
            top = 2 * node + 2;
         if (top == node) begin
            moving = 0;
         end else begin
            t = sort_buf[node];
            sort_buf[node] = sort_buf[top];
            sort_buf[top] = t;
            node = top;
         end
      end
   endfunction

   function automatic void absorb_element(logic [ELEM_W-1:0] v, logic last);
      logic signed [ELEM_W-1:0] t;
      sorted_word_type r;
      words_taken++;
      if (held < CAP) begin
         sort_buf[held] = v;
         held++;
      end else begin
         spilled = 1;
      end
      if (last) begin
         for (int i = held / 2; i > 0; i--)
            sift_element(held, i - 1);
         for (int i = held; i > 1; i--) begin
            t = sort_buf[0];
            sort_buf[0] = sort_buf[i - 1];
            sort_buf[i - 1] = t;
            sift_element(i - 1, 0);
         end
         for (int i = 0; i < held; i++) begin
            r.value = sort_buf[i];
            r.run_end = (i == held - 1);
            r.dropped = spilled;
            sorted_expect.push_back(r);
         end
         held = 0;
         spilled = 0;
      end
   endfunction

   function automatic void check_result();
      sorted_word_type e;
      if (sorted_expect.size() == 0) begin
         $error("unexpected word: sorted_value %h", rsp_tdata);
         errs++;
      end else begin
         e = sorted_expect.pop_front();
         if (rsp_tdata !== e.value) begin
            $error("sorted_value: expected %h, got %h", e.value, rsp_tdata);
            errs++;
         end
         if (rsp_tlast !== e.run_end) begin
            $error("end_of_run: expected %b, got %b", e.run_end, rsp_tlast);
            errs++;
         end
         if (rsp_tuser !== e.dropped) begin
            $error("overflowed: expected %b, got %b", e.dropped, rsp_tuser);
            errs++;
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_element(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (element_feed.size() != 0
                && !(element_feed[0].wait_drain && sorted_expect.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               next_word = element_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_word.value;
               req_tlast <= next_word.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_left <= HOLD_LEN;
         hold_seen <= hold_asks;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic push_word(logic [ELEM_W-1:0] v, logic last, bit drain);
      element_word_type w;
      w.value = v;
      w.last = last;
      w.wait_drain = drain;
      element_feed.push_back(w);
      words_queued++;
   endtask

   function automatic logic [ELEM_W-1:0] pick_value(int kind, int idx);
      logic [ELEM_W-1:0] v;
      case (kind)
         1: v = $urandom_range(7) - 32'd4;
         2: begin
            case ($urandom_range(3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         3: v = 32'd1000 - idx;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic push_set(int size, bit drain);
      int r;
      int kind;
      r = $urandom_range(99);
      kind = (r < 50) ? 0 : (r < 75) ? 1 : (r < 90) ? 2 : 3;
      for (int i = 0; i < size; i++)
         push_word(pick_value(kind, i), i == size - 1, drain && i == 0);
   endtask

   task automatic random_phase(int budget, int big_size);
      int size;
      if (big_size > 0) begin
         push_set(big_size, 0);
         budget -= big_size;
      end
      while (budget > 0) begin
         size = ($urandom_range(99) < 8) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         push_set(size, $urandom_range(99) < 5);
         budget -= size;
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (words_taken != words_queued || sorted_expect.size() != 0);
   endtask

   task automatic set_idling(int send_pct, int rsp_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      stall_pct <= rsp_pct;
   endtask

   initial begin
      wait (reset === 1'b0);
      @(posedge clock);

      // single-element sets at both extremes
      push_word(32'h8000_0000, 1'b1, 1'b0);
      push_word(32'h7fff_ffff, 1'b1, 1'b0);
      // extremes, alternating bits and ties
      push_word(32'h7fff_ffff, 1'b0, 1'b0);
      push_word(32'h8000_0000, 1'b0, 1'b0);
      push_word(32'h0000_0000, 1'b0, 1'b0);
      push_word(32'hffff_ffff, 1'b0, 1'b0);
      push_word(32'h0000_0001, 1'b0, 1'b0);
      push_word(32'h5555_5555, 1'b0, 1'b0);
      push_word(32'haaaa_aaaa, 1'b0, 1'b0);
      push_word(32'd7, 1'b0, 1'b0);
      push_word(32'd7, 1'b0, 1'b0);
      push_word(32'd7, 1'b1, 1'b0);
      // already ascending, then descending
      for (int i = 0; i < 4; i++)
         push_word(32'd1 + i, i == 3, 1'b0);
      for (int i = 0; i < 4; i++)
         push_word(32'd4 - i, i == 3, 1'b0);
      wait_idle();

      // results held off while the sender keeps going
      @(posedge clock);
      hold_asks <= hold_asks + 1;
      for (int s = 0; s < 6; s++)
         push_set(8, 1'b0);
      wait_idle();

      set_idling(0, 0);
      random_phase(60, 64);
      wait_idle();
      set_idling(73, 0);
      random_phase(60, 66);
      wait_idle();
      set_idling(0, 73);
      random_phase(60, 0);
      wait_idle();
      set_idling(36, 36);
      random_phase(60, 70);
      wait_idle();

      repeat (50) @(posedge clock);
      if (errs == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
